>>> rtl/cda_pkg.sv
`timescale 1ns / 1ps

package cda_pkg;

   localparam int ADVANCE_COUNT_W = 10;

   localparam logic [0:0]  ACTION_SET     = 1'b0;
   localparam logic [0:0]  ACTION_ADVANCE = 1'b1;

   localparam logic [11:0] YEAR_MIN  = 12'd1900;
   localparam logic [11:0] YEAR_MAX  = 12'd2100;
   localparam logic [11:0] YEAR_TOP  = 12'd4095;
   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_DEC = 4'd12;
   localparam logic [4:0]  DAY_FIRST = 5'd1;
   localparam logic [4:0]  DAY_LAST  = 5'd31;
   localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;

   // Year position within the 400-year cycle; 1900 sits at 300.
   localparam logic [8:0]  CYCLE_LEN    = 9'd400;
   localparam logic [8:0]  CYCLE_BASE   = 9'd300;
   localparam logic [8:0]  CYCLE_LAST   = 9'd399;
   localparam logic [8:0]  CYCLE_CENT1  = 9'd100;
   localparam logic [8:0]  CYCLE_CENT2  = 9'd200;
   localparam logic [8:0]  CYCLE_CENT3  = 9'd300;

   localparam logic [4:0] MONTH_LEN [0:15] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_MONTH = 3'd1,
      STATUS_BAD_YEAR  = 3'd2,
      STATUS_BAD_DAY   = 3'd3,
      STATUS_SATURATED = 3'd4
   } status_type;

   typedef struct packed {
      logic [0:0]                 action;
      logic [3:0]                 set_month;
      logic [4:0]                 set_day;
      logic [11:0]                set_year;
      logic [ADVANCE_COUNT_W-1:0] advance_count;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  before_day;
      logic [3:0]  before_month;
      logic [11:0] before_year;
      logic [4:0]  after_day;
      logic [3:0]  after_month;
      logic [11:0] after_year;
      logic [2:0]  status;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_RUN    = 2'd1,
      ST_FINISH = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic apply_set;
      logic step;
      logic saturate;
      logic publish;
   } cda_cmd_type;

   typedef struct packed {
      logic is_set;
      logic count_zero;
      logic at_top;
   } cda_stat_type;

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      len = MONTH_LEN[month];
      if (month == MONTH_FEB && leap) begin
         len = FEB_LEAP_DAYS;
      end
      return len;
   endfunction

endpackage

>>> rtl/cda_if.sv
`timescale 1ns / 1ps

interface cda_req_if import cda_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface cda_rsp_if import cda_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/cda_datapath.sv
`timescale 1ns / 1ps

module cda_datapath import cda_pkg::*; #(
   parameter int COUNT_W = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  cda_cmd_type  cmd,
   output cda_stat_type stat,
   output rsp_item_type rsp_item
);

   logic [4:0]         day_ff, day_in;
   logic [3:0]         month_ff, month_in;
   logic [11:0]        year_ff, year_in;
   logic [8:0]         cycle_ff, cycle_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   status_type         status_ff, status_in;

   logic               is_set_ff;
   logic [3:0]         set_month_ff;
   logic [4:0]         set_day_ff;
   logic [11:0]        set_year_ff;
   logic [4:0]         bday_ff;
   logic [3:0]         bmonth_ff;
   logic [11:0]        byear_ff;
   rsp_item_type       rsp_ff;

   logic               leap_cur;
   logic [4:0]         dim_cur;
   logic               set_leap;
   logic [4:0]         set_dim;
   status_type         set_code;
   logic [11:0]        year_off;
   logic [8:0]         cycle_raw;
   logic [8:0]         cycle_load;
   logic [8:0]         cycle_next;

   assign leap_cur = (cycle_ff == '0) ||
                     (cycle_ff[1:0] == 2'b00 && cycle_ff != CYCLE_CENT1 &&
                      cycle_ff != CYCLE_CENT2 && cycle_ff != CYCLE_CENT3);
   assign dim_cur  = days_in(month_ff, leap_cur);

   // Within the loadable year range only 1900 and 2100 break the four-year rule.
   assign set_leap = (set_year_ff[1:0] == 2'b00) && (set_year_ff != YEAR_MIN) &&
                     (set_year_ff != YEAR_MAX);
   assign set_dim  = days_in(set_month_ff, set_leap);

   always_comb begin
      if (set_month_ff < MONTH_JAN || set_month_ff > MONTH_DEC) begin
         set_code = STATUS_BAD_MONTH;
      end else if (set_year_ff < YEAR_MIN || set_year_ff > YEAR_MAX) begin
         set_code = STATUS_BAD_YEAR;
      end else if (set_day_ff < DAY_FIRST || set_day_ff > set_dim) begin
         set_code = STATUS_BAD_DAY;
      end else begin
         set_code = STATUS_OK;
      end
   end

   assign year_off   = set_year_ff - YEAR_MIN;
   assign cycle_raw  = year_off[8:0] + CYCLE_BASE;
   assign cycle_load = (cycle_raw >= CYCLE_LEN) ? cycle_raw - CYCLE_LEN : cycle_raw;
   assign cycle_next = (cycle_ff == CYCLE_LAST) ? '0 : cycle_ff + 9'd1;

   assign stat.is_set     = is_set_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.at_top     = (year_ff == YEAR_TOP) && (month_ff == MONTH_DEC) &&
                            (day_ff == DAY_LAST);

   always_comb begin
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      cycle_in  = cycle_ff;
      count_in  = count_ff;
      status_in = status_ff;
      if (cmd.load) begin
         count_in  = req_item.advance_count[COUNT_W-1:0];
         status_in = STATUS_OK;
      end
      if (cmd.apply_set) begin
         status_in = set_code;
         if (set_code == STATUS_OK) begin
            day_in   = set_day_ff;
            month_in = set_month_ff;
            year_in  = set_year_ff;
            cycle_in = cycle_load;
         end
      end
      if (cmd.saturate) begin
         status_in = STATUS_SATURATED;
      end
      if (cmd.step) begin
         count_in = count_ff - COUNT_W'(1);
         if (day_ff < dim_cur) begin
            day_in = day_ff + 5'd1;
         end else if (month_ff < MONTH_DEC) begin
            month_in = month_ff + 4'd1;
            day_in   = DAY_FIRST;
         end else begin
            year_in  = year_ff + 12'd1;
            cycle_in = cycle_next;
            month_in = MONTH_JAN;
            day_in   = DAY_FIRST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff    <= DAY_FIRST;
         month_ff  <= MONTH_JAN;
         year_ff   <= YEAR_MIN;
         cycle_ff  <= CYCLE_BASE;
         count_ff  <= '0;
         status_ff <= STATUS_OK;
      end else begin
         day_ff    <= day_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
         cycle_ff  <= cycle_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_set_ff    <= (req_item.action == ACTION_SET);
         set_month_ff <= req_item.set_month;
         set_day_ff   <= req_item.set_day;
         set_year_ff  <= req_item.set_year;
         bday_ff      <= day_ff;
         bmonth_ff    <= month_ff;
         byear_ff     <= year_ff;
      end
      if (cmd.publish) begin
         rsp_ff.before_day   <= bday_ff;
         rsp_ff.before_month <= bmonth_ff;
         rsp_ff.before_year  <= byear_ff;
         rsp_ff.after_day    <= day_ff;
         rsp_ff.after_month  <= month_ff;
         rsp_ff.after_year   <= year_ff;
         rsp_ff.status       <= status_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

>>> rtl/cda_ctrl.sv
`timescale 1ns / 1ps

module cda_ctrl import cda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  cda_stat_type stat,
   output cda_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic           out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.is_set || stat.count_zero || stat.at_top) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            if (stat.is_set) begin
               cmd.apply_set = 1'b1;
            end else if (!stat.count_zero) begin
               cmd.saturate = stat.at_top;
               cmd.step     = !stat.at_top;
            end
         end
         ST_FINISH: begin
            cmd.publish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> rtl/calendar_date_advancer_core.sv
`timescale 1ns / 1ps
// A set item loads its date if the date is valid; an advance item steps the date by n days
// (low COUNT_BITS bits of the count), stopping at 31 December 4095. The result is registered
// and held until taken; a new item is accepted only once the last result is published.
// The date register is stepped by one day per cycle.
// Reset is synchronous and active high; it loads 1 January 1900 and empties the output.

module calendar_date_advancer_core import cda_pkg::*; #(
   parameter int COUNT_BITS = 10
) (
   input logic        clock,
   input logic        reset,
   cda_req_if.sink    req_ch,
   cda_rsp_if.source  rsp_ch
);

   localparam int COUNT_W = (COUNT_BITS < ADVANCE_COUNT_W) ? COUNT_BITS : ADVANCE_COUNT_W;

   cda_cmd_type  cmd;
   cda_stat_type stat;

   cda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cda_datapath #(
      .COUNT_W (COUNT_W)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_ch.item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_ch.item)
   );

endmodule

>>> rtl/cda_checker.sv
`timescale 1ns / 1ps

module cda_checker import cda_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("Result item changed or dropped while stalled.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A second item was taken while one was in progress.");

   a_error_keeps_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == STATUS_BAD_MONTH ||
                    rsp_item.status == STATUS_BAD_YEAR ||
                    rsp_item.status == STATUS_BAD_DAY) |->
         rsp_item.after_day == rsp_item.before_day &&
         rsp_item.after_month == rsp_item.before_month &&
         rsp_item.after_year == rsp_item.before_year)
      else $error("A rejected set changed the date.");

   a_saturated_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_SATURATED |->
         rsp_item.after_year == YEAR_TOP && rsp_item.after_month == MONTH_DEC &&
         rsp_item.after_day == DAY_LAST)
      else $error("Saturation reported away from the last date.");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.after_month >= MONTH_JAN && rsp_item.after_month <= MONTH_DEC &&
                    rsp_item.after_day >= DAY_FIRST)
      else $error("Reported date is out of range.");

endmodule

bind calendar_date_advancer_core cda_checker u_cda_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_item  (rsp_ch.item)
);

>>> dv/calendar_date_advancer_core_tb.sv
`timescale 1ns / 1ps

module calendar_date_advancer_core_tb import cda_pkg::*; ();

   localparam int COUNT_BITS  = ADVANCE_COUNT_W;
   localparam int COUNT_MAX   = (1 << ADVANCE_COUNT_W) - 1;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int REPORT_MAX  = 10;

   class calendar_tracker;
      logic [4:0]   day_q;
      logic [3:0]   month_q;
      logic [11:0]  year_q;
      int           count_mask;
      rsp_item_type predicted_dates[$];
      int           mismatches;
      int           stray_results;
      int           reported;
      int           checked;
      int           sets_done;
      int           sets_refused;
      int           advances_done;
      int           days_stepped;
      int           ceiling_hits;

      function new(input int count_bits);
         day_q         = DAY_FIRST;
         month_q       = MONTH_JAN;
         year_q        = YEAR_MIN;
         count_mask    = (1 << count_bits) - 1;
         mismatches    = 0;
         stray_results = 0;
         reported      = 0;
         checked       = 0;
         sets_done     = 0;
         sets_refused  = 0;
         advances_done = 0;
         days_stepped  = 0;
         ceiling_hits  = 0;
      endfunction

      function bit leap_year(input logic [11:0] y);
         return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
      endfunction

      function logic [4:0] month_days(input logic [3:0] m, input logic [11:0] y);
         if (m == MONTH_FEB && leap_year(y)) begin
            return FEB_LEAP_DAYS;
         end
         return MONTH_LEN[m];
      endfunction

      function bit at_top();
         return year_q >= YEAR_TOP && month_q == MONTH_DEC && day_q == DAY_LAST;
      endfunction

      function void roll_one_day();
         if (day_q < month_days(month_q, year_q)) begin
            day_q++;
         end else if (month_q < MONTH_DEC) begin
            month_q++;
            day_q = DAY_FIRST;
         end else begin
            year_q++;
            month_q = MONTH_JAN;
            day_q   = DAY_FIRST;
         end
      endfunction

      // Days still to go before the ceiling, looking no further than cap.
      function int days_to_top(input int cap);
         logic [4:0]  d;
         logic [3:0]  m;
         logic [11:0] y;
         int          n;
         d = day_q;
         m = month_q;
         y = year_q;
         n = 0;
         while (n < cap && !at_top()) begin
            roll_one_day();
            n++;
         end
         day_q   = d;
         month_q = m;
         year_q  = y;
         return n;
      endfunction

      function void note_request(input req_item_type it);
         rsp_item_type r;
         status_type   st;
         int           n;
         int           i;
         r.before_day   = day_q;
         r.before_month = month_q;
         r.before_year  = year_q;
         st = STATUS_OK;
         if (it.action == ACTION_SET) begin
            sets_done++;
            if (it.set_month < MONTH_JAN || it.set_month > MONTH_DEC) begin
               st = STATUS_BAD_MONTH;
            end else if (it.set_year < YEAR_MIN || it.set_year > YEAR_MAX) begin
               st = STATUS_BAD_YEAR;
            end else if (it.set_day < DAY_FIRST ||
                         it.set_day > month_days(it.set_month, it.set_year)) begin
               st = STATUS_BAD_DAY;
            end else begin
               day_q   = it.set_day;
               month_q = it.set_month;
               year_q  = it.set_year;
            end
            if (st != STATUS_OK) begin
               sets_refused++;
            end
         end else begin
            advances_done++;
            n = int'(it.advance_count) & count_mask;
            for (i = 0; i < n; i++) begin
               if (at_top()) begin
                  st = STATUS_SATURATED;
                  ceiling_hits++;
                  break;
               end
               roll_one_day();
               days_stepped++;
            end
         end
         r.after_day   = day_q;
         r.after_month = month_q;
         r.after_year  = year_q;
         r.status      = st;
         predicted_dates.push_back(r);
      endfunction

      function void check_response(input rsp_item_type got);
         rsp_item_type want;
         string        fields;
         if (predicted_dates.size() == 0) begin
            stray_results++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("unexpected result %0d-%0d-%0d to %0d-%0d-%0d status %0d",
                        got.before_year, got.before_month, got.before_day,
                        got.after_year, got.after_month, got.after_day, got.status);
            end
            return;
         end
         want = predicted_dates.pop_front();
         checked++;
         fields = "";
         if (want.before_day !== got.before_day) fields = {fields, " before_day"};
         if (want.before_month !== got.before_month) fields = {fields, " before_month"};
         if (want.before_year !== got.before_year) fields = {fields, " before_year"};
         if (want.after_day !== got.after_day) fields = {fields, " after_day"};
         if (want.after_month !== got.after_month) fields = {fields, " after_month"};
         if (want.after_year !== got.after_year) fields = {fields, " after_year"};
         if (want.status !== got.status) fields = {fields, " status"};
         if (fields != "") begin
            mismatches++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("result %0d differs in%s: expected %0d-%0d-%0d to %0d-%0d-%0d status %0d",
                        checked, fields,
                        want.before_year, want.before_month, want.before_day,
                        want.after_year, want.after_month, want.after_day, want.status);
               $display("   actual %0d-%0d-%0d to %0d-%0d-%0d status %0d",
                        got.before_year, got.before_month, got.before_day,
                        got.after_year, got.after_month, got.after_day, got.status);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   cycles_run;

   calendar_tracker sb;

   cda_req_if req_ch ();
   cda_rsp_if rsp_ch ();

   calendar_date_advancer_core #(
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles_run = 0;
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("calendar_date_advancer_core_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_response(rsp_ch.item);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // The prediction is made at the edge that accepts the item, so the next
   // item may be chosen from the date the block will hold.
   task automatic send_item(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.item  <= it;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      sb.note_request(it);
   endtask

   task automatic set_item(input logic [3:0] m, input logic [4:0] d,
                           input logic [11:0] y, input int n);
      req_item_type it;
      it.action        = ACTION_SET;
      it.set_month     = m;
      it.set_day       = d;
      it.set_year      = y;
      it.advance_count = ADVANCE_COUNT_W'(n);
      send_item(it);
   endtask

   task automatic advance_item(input int n);
      req_item_type it;
      it.action        = ACTION_ADVANCE;
      it.set_month     = 4'($urandom_range(15));
      it.set_day       = 5'($urandom_range(31));
      it.set_year      = 12'($urandom_range(4095));
      it.advance_count = ADVANCE_COUNT_W'(n);
      send_item(it);
   endtask

   task automatic random_item();
      logic [3:0]  m;
      logic [4:0]  d;
      logic [4:0]  len;
      logic [11:0] y;
      int          roll;
      roll = $urandom_range(99);
      if (roll < 40) begin
         m = 4'($urandom_range(12, 1));
         case ($urandom_range(7))
            0: y = YEAR_MIN;
            1: y = 12'd2000;
            2: y = YEAR_MAX;
            default: y = 12'($urandom_range(2100, 1900));
         endcase
         len = sb.month_days(m, y);
         if (roll < 28) begin
            if ($urandom_range(2) == 0) begin
               d = len - 5'($urandom_range(1));
            end else begin
               d = 5'($urandom_range(len, 1));
            end
         end else if (roll < 34) begin
            d = (len == DAY_LAST) ? 5'd0 : 5'($urandom_range(31, len + 1));
         end else begin
            m = 4'($urandom_range(15));
            d = 5'($urandom_range(31));
            y = 12'($urandom_range(4095));
         end
         set_item(m, d, y, $urandom_range(COUNT_MAX));
      end else if (roll < 85) begin
         advance_item($urandom_range(40));
      end else if (roll < 95) begin
         advance_item($urandom_range(400));
      end else begin
         advance_item($urandom_range(COUNT_MAX));
      end
   endtask

   initial begin
      req_item_type it;
      sb            = new(COUNT_BITS);
      send_idle_pct = 22;
      recv_idle_pct = 50;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.item   = '0;
      rsp_ch.ready  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      advance_item(0);
      set_item(4'd0, DAY_LAST, YEAR_TOP, 0);
      set_item(4'd15, 5'd0, 12'd0, COUNT_MAX);
      set_item(4'd13, DAY_FIRST, 12'd2000, 0);
      set_item(MONTH_DEC, 5'd0, 12'd1899, 0);
      set_item(MONTH_JAN, DAY_FIRST, 12'd2101, 0);
      set_item(MONTH_JAN, DAY_FIRST, YEAR_TOP, 0);
      set_item(MONTH_JAN, 5'd0, YEAR_MIN, 0);
      set_item(4'd4, DAY_LAST, 12'd2023, 0);
      set_item(MONTH_FEB, 5'd29, YEAR_MIN, 0);
      set_item(MONTH_FEB, 5'd29, YEAR_MAX, 0);
      set_item(MONTH_FEB, 5'd29, 12'd2024, 0);
      set_item(MONTH_FEB, 5'd28, 12'd2000, 0);
      advance_item(1);
      advance_item(1);
      set_item(MONTH_FEB, 5'd28, 12'd2023, 0);
      advance_item(1);
      set_item(MONTH_DEC, DAY_LAST, YEAR_MAX, COUNT_MAX);
      advance_item(1);
      set_item(MONTH_JAN, DAY_FIRST, YEAR_MIN, 0);
      it        = '1;
      it.action = ACTION_ADVANCE;
      send_item(it);
      set_item(4'd6, 5'd30, 12'd1999, 0);
      advance_item(31);

      repeat (195) random_item();
      send_idle_pct = 50;
      recv_idle_pct = 22;
      repeat (195) random_item();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (190) random_item();

      // Climb from the last loadable day to the ceiling, landing on it exactly.
      set_item(MONTH_DEC, DAY_LAST, YEAR_MAX, 0);
      while (!sb.at_top()) begin
         advance_item(sb.days_to_top(COUNT_MAX));
      end
      advance_item(1);
      advance_item(0);
      advance_item(COUNT_MAX);
      set_item(MONTH_JAN, DAY_FIRST, YEAR_MIN, 0);
      repeat (10) random_item();
      req_ch.valid <= 1'b0;

      while (sb.predicted_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("%0d date loads (%0d refused) and %0d advances stepping %0d days.",
               sb.sets_done, sb.sets_refused, sb.advances_done, sb.days_stepped);
      $display("The 4095 ceiling stopped %0d advances; %0d results were checked.",
               sb.ceiling_hits, sb.checked);
      if (sb.mismatches == 0 && sb.stray_results == 0 &&
          sb.predicted_dates.size() == 0) begin
         $display("calendar_date_advancer_core_tb passed");
      end else begin
         $display("calendar_date_advancer_core_tb failed");
      end
      $finish;
   end

endmodule
